### design/ave_pkg.sv
// Shared types, constants and character helpers for the attribute value text encoder.
// Used by ave_cfg, ave_expand, ave_serial and attr_value_text_encoder.
package ave_pkg;

  // Most characters that one input item can give rise to.
  localparam int unsigned MaxChars = 6;

  // Encoding mode codes; the fourth code behaves as quoted text.
  localparam logic [1:0] ModeText = 2'd0;
  localparam logic [1:0] ModeHex  = 2'd1;
  localparam logic [1:0] ModeB64  = 2'd2;

  // Register byte addresses.
  localparam logic [1:0] AddrMode = 2'd0;

  // Framing and escape characters.
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ChS      = 8'h73;
  localparam logic [7:0] ChPad    = 8'h3D;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] PrintLo  = 8'h20;
  localparam logic [7:0] PrintHi  = 8'h7E;

  typedef logic [7:0] char_t;

  // Characters produced for one item, first character in entry 0.
  typedef struct packed {
    char_t [MaxChars-1:0] chars;
    logic [2:0]           count;
    logic                 last;
  } ave_list_t;

  // Encoder state carried from one item to the next.
  typedef struct packed {
    logic        started;
    logic [15:0] group_bytes;
    logic [1:0]  group_count;
  } ave_state_t;

  // One lowercase hexadecimal digit.
  function automatic char_t hex_char(input logic [3:0] v);
    char_t c;
    if (v < 4'd10) begin
      c = ChZero + {4'b0, v};
    end else begin
      c = ChLowA + {4'b0, v} - 8'd10;
    end
    return c;
  endfunction

  // One character of the standard base64 alphabet.
  function automatic char_t b64_char(input logic [5:0] v);
    char_t c;
    if (v < 6'd26) begin
      c = ChUpA + {2'b0, v};
    end else if (v < 6'd52) begin
      c = ChLowA + {2'b0, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = ChZero + {2'b0, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = ChPlus;
    end else begin
      c = ChSlash;
    end
    return c;
  endfunction

endpackage

### design/ave_cfg.sv
// APB-style register port holding the encoding mode.
// Depends on ave_pkg for the register address.
module ave_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o,
  output logic [1:0]  mode_o
);
  import ave_pkg::*;

  logic [1:0] mode_q, mode_d;
  logic       wr_en;

  // A write lands in the access phase; the port never stalls.
  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i && (paddr_i == AddrMode);

  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = pwdata_i[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeText;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Read back the mode; other addresses read as zero.
  assign prdata_o = (paddr_i == AddrMode) ? {30'b0, mode_q} : 32'b0;
  assign mode_o   = mode_q;

endmodule

### design/ave_expand.sv
// Expands one input byte into its list of text characters and keeps the encoder state.
// Depends on ave_pkg for the list and state types and the alphabet helpers.
module ave_expand (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          data_byte_i,
  input  logic                is_last_i,
  input  logic                empty_value_i,
  output ave_pkg::ave_list_t  list_o
);
  import ave_pkg::*;

  ave_state_t state_q, state_d;

  always_comb begin
    char_t       chars [8];
    logic [2:0]  n;
    logic [15:0] gb;
    logic [1:0]  gc;
    logic        full;
    logic        do_quad;
    logic [23:0] word;
    logic [1:0]  have;

    for (int i = 0; i < 8; i++) begin
      chars[i] = ChZero;
    end
    n       = 3'd0;
    gb      = state_q.group_bytes;
    gc      = state_q.group_count;
    full    = 1'b0;
    do_quad = 1'b0;
    word    = 24'b0;
    have    = 2'd0;

    case (mode_i)
      ModeHex: begin
        if (!state_q.started) begin
          chars[n] = ChZero; n = n + 3'd1;
          chars[n] = ChX;    n = n + 3'd1;
        end
        if (!empty_value_i) begin
          chars[n] = hex_char(data_byte_i[7:4]); n = n + 3'd1;
          chars[n] = hex_char(data_byte_i[3:0]); n = n + 3'd1;
        end
      end
      ModeB64: begin
        if (!state_q.started) begin
          chars[n] = ChZero; n = n + 3'd1;
          chars[n] = ChS;    n = n + 3'd1;
        end
        // Collect bytes into the pending group; the third byte completes it.
        if (!empty_value_i) begin
          if (state_q.group_count == 2'd0) begin
            gb = {data_byte_i, 8'h00};
            gc = 2'd1;
          end else if (state_q.group_count == 2'd1) begin
            gb = {state_q.group_bytes[15:8], data_byte_i};
            gc = 2'd2;
          end else begin
            full = 1'b1;
            gb   = 16'h0000;
            gc   = 2'd0;
          end
        end
        // A full group and a closing flush never happen for the same item.
        if (full) begin
          do_quad = 1'b1;
          word    = {state_q.group_bytes, data_byte_i};
          have    = 2'd3;
        end else if (is_last_i && (gc != 2'd0)) begin
          do_quad = 1'b1;
          word    = {gb, 8'h00};
          have    = gc;
        end
        if (do_quad) begin
          chars[n] = b64_char(word[23:18]); n = n + 3'd1;
          chars[n] = b64_char(word[17:12]); n = n + 3'd1;
          chars[n] = (have > 2'd1) ? b64_char(word[11:6]) : ChPad; n = n + 3'd1;
          chars[n] = (have > 2'd2) ? b64_char(word[5:0])  : ChPad; n = n + 3'd1;
        end
      end
      default: begin
        // Quoted text with escapes.
        if (!state_q.started) begin
          chars[n] = ChQuote; n = n + 3'd1;
        end
        if (!empty_value_i) begin
          if ((data_byte_i == ChBslash) || (data_byte_i == ChQuote)) begin
            chars[n] = ChBslash;    n = n + 3'd1;
            chars[n] = data_byte_i; n = n + 3'd1;
          end else if ((data_byte_i >= PrintLo) && (data_byte_i <= PrintHi)) begin
            chars[n] = data_byte_i; n = n + 3'd1;
          end else begin
            chars[n] = ChBslash;                             n = n + 3'd1;
            chars[n] = ChZero + {6'b0, data_byte_i[7:6]};    n = n + 3'd1;
            chars[n] = ChZero + {5'b0, data_byte_i[5:3]};    n = n + 3'd1;
            chars[n] = ChZero + {5'b0, data_byte_i[2:0]};    n = n + 3'd1;
          end
        end
        if (is_last_i) begin
          chars[n] = ChQuote; n = n + 3'd1;
        end
      end
    endcase

    for (int i = 0; i < MaxChars; i++) begin
      list_o.chars[i] = chars[i];
    end
    list_o.count = n;
    list_o.last  = is_last_i;

    // Closing a value clears everything, otherwise the prefix is done.
    if (is_last_i) begin
      state_d = '0;
    end else begin
      state_d.started     = 1'b1;
      state_d.group_bytes = gb;
      state_d.group_count = gc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept_i) begin
      state_q <= state_d;
    end
  end

endmodule

### design/ave_serial.sv
// Holds one item's character list and hands it out one character per beat.
// Depends on ave_pkg for the list type.
module ave_serial (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ave_pkg::ave_list_t list_i,
  output logic               load_ready_o,
  output logic [7:0]         out_char_o,
  output logic               last_char_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);
  import ave_pkg::*;

  ave_list_t  list_q;
  logic       lvalid_q;
  logic [2:0] idx_q;
  char_t      ochar_q;
  logic       olast_q;
  logic       ovalid_q;

  logic move;
  logic lend;

  // A character moves into the output register when that register is free.
  assign move         = lvalid_q && (!ovalid_q || out_ready_i);
  assign lend         = (idx_q == (list_q.count - 3'd1));
  assign load_ready_o = !lvalid_q || (move && lend);

  // List stage: an item with no characters leaves nothing behind.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvalid_q <= 1'b0;
      idx_q    <= 3'd0;
    end else if (load_i && (list_i.count != 3'd0)) begin
      lvalid_q <= 1'b1;
      idx_q    <= 3'd0;
    end else if (move && lend) begin
      lvalid_q <= 1'b0;
      idx_q    <= 3'd0;
    end else if (move) begin
      idx_q    <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      list_q <= list_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      ochar_q  <= '0;
      olast_q  <= 1'b0;
    end else if (move) begin
      ovalid_q <= 1'b1;
      ochar_q  <= list_q.chars[idx_q];
      olast_q  <= list_q.last && lend;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  assign out_char_o  = ochar_q;
  assign last_char_o = olast_q;
  assign out_valid_o = ovalid_q;

endmodule

### design/attr_value_text_encoder.sv
// Attribute value text encoder: one raw byte in per beat, one text character out per beat.
// Path: the first character of an item is held in the list register, then in the output register.
// Throughput: an item holds the list stage until its last character moves out (at most six
// characters); items giving no characters go at one per cycle while the list stage is empty.
// Reset clears the mode to quoted text, the encoder state and all valid flags at once.
module attr_value_text_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  logic        is_last_i,
  input  logic        empty_value_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [7:0]  out_char_o,
  output logic        last_char_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import ave_pkg::*;

  logic       accept;
  logic [1:0] mode;
  ave_list_t  list;

  assign accept = in_valid_i && in_ready_o;

  ave_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .mode_o    (mode)
  );

  ave_expand u_expand (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .mode_i        (mode),
    .data_byte_i   (data_byte_i),
    .is_last_i     (is_last_i),
    .empty_value_i (empty_value_i),
    .list_o        (list)
  );

  ave_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .list_i       (list),
    .load_ready_o (in_ready_o),
    .out_char_o   (out_char_o),
    .last_char_o  (last_char_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

endmodule
